FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL; all sample on clock and are off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge.
`define ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// Consequent must hold at the same edge as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/igmp_mt_pkg.sv
// ----------------------------------------------------------------------------
// igmp_mt_pkg
// Types, codes and constants of the IGMP membership table.
// ----------------------------------------------------------------------------
`default_nettype none

package igmp_mt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int REF_BITS_DEF      = 16;

   localparam int DEV_W = 3;
   localparam int GRP_W = 32;

   localparam logic [7:0]       TYPE_QUERY   = 8'h11;
   localparam logic [GRP_W-1:0] ALL_ROUTERS  = 32'hE000_0002;
   localparam logic [3:0]       MCAST_PREFIX = 4'hE;

   typedef enum logic [1:0] {
      ACT_JOIN   = 2'd0,
      ACT_LEAVE  = 2'd1,
      ACT_PACKET = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_INVALID    = 2'd1,
      STAT_FULL       = 2'd2,
      STAT_NOT_MEMBER = 2'd3
   } status_type;

   typedef enum logic {
      KIND_REPORT = 1'b0,
      KIND_LEAVE  = 1'b1
   } kind_type;

   typedef struct packed {
      logic             valid;
      logic [DEV_W-1:0] device;
      logic [GRP_W-1:0] group;
   } entry_type;

   typedef struct packed {
      logic hit;
      logic free;
   } match_type;

endpackage

`default_nettype wire

FILE: src/igmp_membership_table.sv
// ----------------------------------------------------------------------------
// igmp_membership_table
// Reference-counted IGMPv2 host membership table keyed by device and group.
// ----------------------------------------------------------------------------
// One compare unit walks the table one slot per clock, except while a query
// report waits for the output register. A join or leave is accepted, scans the
// table until a hit or the last slot, takes an update step on a hit and then
// loads the result register once the output is free. A query is accepted, scans
// every entry and, when any entry matched, flushes the final report; each report
// is one word and the scan holds while a report waits for the output register.
// An invalid join group goes straight from acceptance to the result register;
// ignored packets and unused actions are absorbed on acceptance. A new word is
// accepted only when the sequencer is idle; a finished result may still wait in
// the output register at that time.
`default_nettype none
`include "assert_macros.svh"

module igmp_membership_table
   import igmp_mt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int REF_BITS      = REF_BITS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_action,
   input  logic [DEV_W-1:0] req_device,
   input  logic [GRP_W-1:0] req_group,
   input  logic             req_is_loopback,
   input  logic [7:0]       req_msg_type,
   input  logic             req_packet_ok,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_send_valid,
   output logic             rsp_send_kind,
   output logic [GRP_W-1:0] rsp_send_group,
   output logic [GRP_W-1:0] rsp_dest_addr,
   output logic             rsp_last
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};
   localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   action_type       act_ff, act_in;
   logic [DEV_W-1:0] dev_ff, dev_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic             loop_ff, loop_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             pend_ff, pend_in;

   status_type       res_status_ff, res_status_in;
   logic             res_send_ff, res_send_in;
   kind_type         res_kind_ff, res_kind_in;
   logic [GRP_W-1:0] res_group_ff, res_group_in;
   logic [GRP_W-1:0] res_dest_ff, res_dest_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_send_valid_ff, rsp_send_valid_in;
   logic             rsp_send_kind_ff, rsp_send_kind_in;
   logic [GRP_W-1:0] rsp_send_group_ff, rsp_send_group_in;
   logic [GRP_W-1:0] rsp_dest_addr_ff, rsp_dest_addr_in;
   logic             rsp_last_ff, rsp_last_in;

   entry_type           rd_entry;
   logic [REF_BITS-1:0] rd_refs;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   entry_type           wr_entry;
   logic [REF_BITS-1:0] wr_refs;

   match_type           cmp_res;
   logic                match_any;
   logic                out_free;
   logic                last_idx;
   logic                advance;
   logic [REF_BITS-1:0] refs_dec;
   action_type          req_act;

   igmp_mt_store #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .REF_BITS     (REF_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (idx_ff),
      .rd_entry(rd_entry),
      .rd_refs (rd_refs),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_entry(wr_entry),
      .wr_refs (wr_refs)
   );

   igmp_mt_cmp u_cmp (
      .entry     (rd_entry),
      .key_device(dev_ff),
      .key_group (grp_ff),
      .match_any (match_any),
      .result    (cmp_res)
   );

   assign match_any = (act_ff == ACT_PACKET) && (grp_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_idx  = (idx_ff == LAST_IDX);
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign req_act   = action_type'(req_action);
   assign refs_dec  = (rd_refs == '0) ? '0 : rd_refs - REF_ONE;
   assign advance   = !(cmp_res.hit && pend_ff && !out_free);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      act_in        = act_ff;
      dev_in        = dev_ff;
      grp_in        = grp_ff;
      loop_in       = loop_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_send_in   = res_send_ff;
      res_kind_in   = res_kind_ff;
      res_group_in  = res_group_ff;
      res_dest_in   = res_dest_ff;

      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_send_valid_in = rsp_send_valid_ff;
      rsp_send_kind_in  = rsp_send_kind_ff;
      rsp_send_group_in = rsp_send_group_ff;
      rsp_dest_addr_in  = rsp_dest_addr_ff;
      rsp_last_in       = rsp_last_ff;

      wr_en    = 1'b0;
      wr_idx   = idx_ff;
      wr_entry = rd_entry;
      wr_refs  = rd_refs;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in        = req_act;
               dev_in        = req_device;
               grp_in        = req_group;
               loop_in       = req_is_loopback;
               idx_in        = '0;
               free_found_in = 1'b0;
               pend_in       = 1'b0;
               res_status_in = STAT_OK;
               res_send_in   = 1'b0;
               res_kind_in   = KIND_REPORT;
               res_group_in  = '0;
               res_dest_in   = '0;
               unique case (req_action)
                  ACT_JOIN: begin
                     if (req_group[GRP_W-1 -: 4] != MCAST_PREFIX) begin
                        res_status_in = STAT_INVALID;
                        state_in      = ST_EMIT;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_LEAVE: begin
                     state_in = ST_SCAN;
                  end
                  ACT_PACKET: begin
                     if (req_packet_ok && (req_msg_type == TYPE_QUERY)) begin
                        res_send_in = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (act_ff != ACT_PACKET) begin
               if (cmp_res.hit) begin
                  state_in = ST_UPDATE;
               end else begin
                  if (cmp_res.free && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = idx_ff;
                  end
                  if (last_idx) begin
                     state_in = ST_EMIT;
                     if (act_ff == ACT_JOIN) begin
                        if (free_found_ff || cmp_res.free) begin
                           wr_en           = 1'b1;
                           wr_idx          = free_found_ff ? free_idx_ff : idx_ff;
                           wr_entry.valid  = 1'b1;
                           wr_entry.device = dev_ff;
                           wr_entry.group  = grp_ff;
                           wr_refs         = REF_ONE;
                           res_status_in   = STAT_OK;
                           res_send_in     = !loop_ff;
                           res_group_in    = loop_ff ? '0 : grp_ff;
                           res_dest_in     = loop_ff ? '0 : grp_ff;
                        end else begin
                           res_status_in = STAT_FULL;
                        end
                     end else begin
                        res_status_in = STAT_NOT_MEMBER;
                     end
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end else begin
               if (cmp_res.hit && pend_ff && out_free) begin
                  rsp_valid_in      = 1'b1;
                  rsp_status_in     = STAT_OK;
                  rsp_send_valid_in = 1'b1;
                  rsp_send_kind_in  = KIND_REPORT;
                  rsp_send_group_in = res_group_ff;
                  rsp_dest_addr_in  = res_group_ff;
                  rsp_last_in       = 1'b0;
               end
               if (advance) begin
                  if (cmp_res.hit) begin
                     pend_in      = 1'b1;
                     res_group_in = rd_entry.group;
                     res_dest_in  = rd_entry.group;
                  end
                  if (last_idx) begin
                     state_in = (pend_ff || cmp_res.hit) ? ST_EMIT : ST_IDLE;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end
         end

         ST_UPDATE: begin
            wr_en    = 1'b1;
            state_in = ST_EMIT;
            if (act_ff == ACT_JOIN) begin
               wr_refs = (rd_refs == REF_MAX) ? rd_refs : rd_refs + REF_ONE;
            end else begin
               wr_refs        = refs_dec;
               wr_entry.valid = (refs_dec != '0);
               if ((refs_dec == '0) && !loop_ff) begin
                  res_send_in  = 1'b1;
                  res_kind_in  = KIND_LEAVE;
                  res_group_in = grp_ff;
                  res_dest_in  = ALL_ROUTERS;
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = res_status_ff;
               rsp_send_valid_in = res_send_ff;
               rsp_send_kind_in  = res_kind_ff;
               rsp_send_group_in = res_group_ff;
               rsp_dest_addr_in  = res_dest_ff;
               rsp_last_in       = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff            <= idx_in;
      act_ff            <= act_in;
      dev_ff            <= dev_in;
      grp_ff            <= grp_in;
      loop_ff           <= loop_in;
      free_found_ff     <= free_found_in;
      free_idx_ff       <= free_idx_in;
      pend_ff           <= pend_in;
      res_status_ff     <= res_status_in;
      res_send_ff       <= res_send_in;
      res_kind_ff       <= res_kind_in;
      res_group_ff      <= res_group_in;
      res_dest_ff       <= res_dest_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_send_valid_ff <= rsp_send_valid_in;
      rsp_send_kind_ff  <= rsp_send_kind_in;
      rsp_send_group_ff <= rsp_send_group_in;
      rsp_dest_addr_ff  <= rsp_dest_addr_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_send_valid = rsp_send_valid_ff;
   assign rsp_send_kind  = rsp_send_kind_ff;
   assign rsp_send_group = rsp_send_group_ff;
   assign rsp_dest_addr  = rsp_dest_addr_ff;
   assign rsp_last       = rsp_last_ff;

   // update is only entered on a hit, and the scan index holds there
   `ASSERT_IMPLIES(a_update_on_hit, state_ff == ST_UPDATE, cmp_res.hit)
   // a word without a send carries no addresses
   `ASSERT_IMPLIES(a_nosend_zero, rsp_valid && !rsp_send_valid,
                   (rsp_send_group == '0) && (rsp_dest_addr == '0))
   // a leave message is the single word of its item and goes to all routers
   `ASSERT_IMPLIES(a_leave_dest, rsp_valid && rsp_send_valid && (rsp_send_kind == KIND_LEAVE),
                   rsp_last && (rsp_dest_addr == ALL_ROUTERS))
   // an error status never opens a run of reports
   `ASSERT_IMPLIES(a_error_last, rsp_valid && (rsp_status != STAT_OK), rsp_last)

endmodule

`default_nettype wire

FILE: src/igmp_mt_cmp.sv
// ----------------------------------------------------------------------------
// igmp_mt_cmp
// Shared key compare: checks one table entry against the lookup key.
// ----------------------------------------------------------------------------
`default_nettype none

module igmp_mt_cmp
   import igmp_mt_pkg::*;
(
   input  entry_type        entry,
   input  logic [DEV_W-1:0] key_device,
   input  logic [GRP_W-1:0] key_group,
   input  logic             match_any,
   output match_type        result
);

   assign result.hit  = entry.valid && (entry.device == key_device) &&
                        (match_any || (entry.group == key_group));
   assign result.free = !entry.valid;

endmodule

`default_nettype wire

FILE: src/igmp_mt_store.sv
// ----------------------------------------------------------------------------
// igmp_mt_store
// Entry storage: valid bits, reference counts, device and group per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module igmp_mt_store
   import igmp_mt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int REF_BITS      = REF_BITS_DEF,
   localparam int IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_W-1:0]    rd_idx,
   output entry_type           rd_entry,
   output logic [REF_BITS-1:0] rd_refs,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  entry_type           wr_entry,
   input  logic [REF_BITS-1:0] wr_refs
);

   logic                valid_ff  [TABLE_ENTRIES];
   logic [DEV_W-1:0]    device_ff [TABLE_ENTRIES];
   logic [GRP_W-1:0]    group_ff  [TABLE_ENTRIES];
   logic [REF_BITS-1:0] refs_ff   [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (wr_en && (wr_idx == IDX_W'(i))) begin
            valid_ff[i] <= wr_entry.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         device_ff[wr_idx] <= wr_entry.device;
         group_ff[wr_idx]  <= wr_entry.group;
         refs_ff[wr_idx]   <= wr_refs;
      end
   end

   assign rd_entry.valid  = valid_ff[rd_idx];
   assign rd_entry.device = device_ff[rd_idx];
   assign rd_entry.group  = group_ff[rd_idx];
   assign rd_refs         = refs_ff[rd_idx];

endmodule

`default_nettype wire
